// File: sv/line_fold_interval_table_core_macros.svh
// Assertion macros for the fold table core.
// Used by the top level only; no other dependencies.
`ifndef LINE_FOLD_INTERVAL_TABLE_CORE_MACROS_SVH
`define LINE_FOLD_INTERVAL_TABLE_CORE_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define LFIT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("fold table assertion failed");
// Cause in one cycle implies effect in the next.
`define LFIT_ASSERT_NEXT(lbl, clk, rstn, cause, effect) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cause) |=> (effect)) \
        else $error("fold table sequencing assertion failed");
`else
`define LFIT_ASSERT(lbl, clk, rstn, prop)
`define LFIT_ASSERT_NEXT(lbl, clk, rstn, cause, effect)
`endif

`endif

// File: sv/lfit_pkg.sv
// Shared constants, types and command/status structs of the fold table core.
// No dependencies; imported by the controller, datapath and top level.
package lfit_pkg;

    localparam int MAX_FOLDS  = 16;
    localparam int LINE_BITS  = 20;
    localparam int AFTER_BITS = LINE_BITS + 1;
    localparam int IDX_BITS   = (MAX_FOLDS > 1) ? $clog2(MAX_FOLDS) : 1;
    localparam int CNT_BITS   = $clog2(MAX_FOLDS + 1);

    typedef logic [LINE_BITS-1:0]  t_line;
    typedef logic [AFTER_BITS-1:0] t_after;
    typedef logic [CNT_BITS-1:0]   t_cnt;
    typedef logic [IDX_BITS-1:0]   t_addr;

    typedef struct packed {
        t_line start_line;
        t_line end_line;
    } t_entry;

    // Scan index operations
    localparam logic [2:0] IDX_HOLD = 3'd0;
    localparam logic [2:0] IDX_ZERO = 3'd1;
    localparam logic [2:0] IDX_TOP  = 3'd2;
    localparam logic [2:0] IDX_INC  = 3'd3;
    localparam logic [2:0] IDX_DEC  = 3'd4;

    // Result register load operations
    localparam logic [1:0] OUT_NONE   = 2'd0;
    localparam logic [1:0] OUT_QHIT   = 2'd1;
    localparam logic [1:0] OUT_QMISS  = 2'd2;
    localparam logic [1:0] OUT_CREATE = 2'd3;

    typedef struct packed {
        logic       load;
        logic [2:0] idx_op;
        logic       save_p;
        logic       wr_end;
        logic       wr_shift;
        logic       wr_insert;
        logic [1:0] out_op;
        logic       out_refresh;
        logic       out_full;
    } t_cmd;

    typedef struct packed {
        logic in_query;
        logic is_query;
        logic in_range;
        logic start_eq;
        logic start_lt;
        logic end_ge;
        logic end_lt_to;
        logic idx_eq_p;
        logic p_eq_count;
        logic full;
        logic out_free;
    } t_sts;

endpackage

// File: sv/lfit_ctrl.sv
// Sequencer of the fold table core: head scan, holder scan, shift and insert.
// Depends on lfit_pkg; drives the datapath through t_cmd, reads t_sts.
module lfit_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  lfit_pkg::t_sts i_sts,
    output lfit_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);
    import lfit_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_HEAD   = 3'd1;
    localparam logic [2:0] S_HOLD   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_INSERT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_hit;
    logic       w_miss;

    assign w_hit  = i_sts.in_range && i_sts.end_ge && i_sts.start_lt;
    assign w_miss = !i_sts.in_range || !i_sts.end_ge;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.idx_op = i_sts.in_query ? IDX_TOP : IDX_ZERO;
                    n_state      = i_sts.in_query ? S_HOLD : S_HEAD;
                end
            end
            S_HEAD: begin
                if (!i_sts.in_range || (!i_sts.start_eq && !i_sts.start_lt)) begin
                    o_cmd.save_p = 1'b1;
                    o_cmd.idx_op = IDX_TOP;
                    n_state      = S_HOLD;
                end else if (i_sts.start_eq) begin
                    if (i_sts.out_free) begin
                        o_cmd.wr_end      = i_sts.end_lt_to;
                        o_cmd.out_op      = OUT_CREATE;
                        o_cmd.out_refresh = i_sts.end_lt_to;
                        n_state           = S_IDLE;
                    end
                end else begin
                    o_cmd.idx_op = IDX_INC;
                end
            end
            S_HOLD: begin
                if (w_hit) begin
                    if (i_sts.out_free) begin
                        if (i_sts.is_query) begin
                            o_cmd.out_op = OUT_QHIT;
                        end else begin
                            o_cmd.wr_end      = i_sts.end_lt_to;
                            o_cmd.out_op      = OUT_CREATE;
                            o_cmd.out_refresh = i_sts.end_lt_to;
                        end
                        n_state = S_IDLE;
                    end
                end else if (w_miss) begin
                    if (i_sts.is_query || i_sts.full) begin
                        if (i_sts.out_free) begin
                            o_cmd.out_op   = i_sts.is_query ? OUT_QMISS : OUT_CREATE;
                            o_cmd.out_full = !i_sts.is_query;
                            n_state        = S_IDLE;
                        end
                    end else if (i_sts.p_eq_count) begin
                        n_state = S_INSERT;
                    end else begin
                        o_cmd.idx_op = IDX_TOP;
                        n_state      = S_SHIFT;
                    end
                end else begin
                    o_cmd.idx_op = IDX_DEC;
                end
            end
            S_SHIFT: begin
                o_cmd.wr_shift = 1'b1;
                if (i_sts.idx_eq_p) begin
                    n_state = S_INSERT;
                end else begin
                    o_cmd.idx_op = IDX_DEC;
                end
            end
            S_INSERT: begin
                if (i_sts.out_free) begin
                    o_cmd.wr_insert   = 1'b1;
                    o_cmd.out_op      = OUT_CREATE;
                    o_cmd.out_refresh = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/lfit_dpath.sv
// Datapath of the fold table core: fold memory, scan index, compares, result register.
// Depends on lfit_pkg; controlled by lfit_ctrl through t_cmd.
module lfit_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lfit_pkg::t_cmd  i_cmd,
    output lfit_pkg::t_sts  o_sts,
    input  logic            i_req_type,
    input  lfit_pkg::t_line i_line,
    input  lfit_pkg::t_line i_end_line,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic            o_contained,
    output lfit_pkg::t_line o_head_line,
    output lfit_pkg::t_after o_line_after,
    output lfit_pkg::t_line o_heading_line,
    output logic            o_refresh_needed,
    output logic            o_table_full
);
    import lfit_pkg::*;

    t_entry r_mem [MAX_FOLDS];
    t_entry r_rd;
    t_cnt   r_count;
    t_cnt   r_idx;
    t_cnt   n_idx;
    t_cnt   r_p;
    logic   r_type;
    t_line  r_line;
    t_line  r_to;
    logic   r_out_valid;
    logic   w_wr_en;
    t_addr  w_wr_addr;
    t_entry w_wr_data;
    t_cnt   w_idx_inc;

    assign w_idx_inc = r_idx + t_cnt'(1);

    always_comb begin
        case (i_cmd.idx_op)
            IDX_ZERO: n_idx = '0;
            IDX_TOP:  n_idx = r_count - t_cnt'(1);
            IDX_INC:  n_idx = w_idx_inc;
            IDX_DEC:  n_idx = r_idx - t_cnt'(1);
            default:  n_idx = r_idx;
        endcase
    end

    // One write port: extend in place, shift up by one, or insert at p.
    always_comb begin
        w_wr_en   = i_cmd.wr_end || i_cmd.wr_shift || i_cmd.wr_insert;
        w_wr_addr = r_idx[IDX_BITS-1:0];
        w_wr_data = '{start_line: r_rd.start_line, end_line: r_to};
        if (i_cmd.wr_shift) begin
            w_wr_addr = w_idx_inc[IDX_BITS-1:0];
            w_wr_data = r_rd;
        end else if (i_cmd.wr_insert) begin
            w_wr_addr = r_p[IDX_BITS-1:0];
            w_wr_data = '{start_line: r_line, end_line: r_to};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[n_idx[IDX_BITS-1:0]];
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.save_p) begin
            r_p <= r_idx;
        end
        if (i_cmd.load) begin
            r_type <= i_req_type;
            r_line <= i_line;
            r_to   <= i_end_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.wr_insert) begin
            r_count <= r_count + t_cnt'(1);
        end
    end

    always_comb begin
        o_sts.in_query   = i_req_type;
        o_sts.is_query   = r_type;
        o_sts.in_range   = (r_idx < r_count);
        o_sts.start_eq   = (r_rd.start_line == r_line);
        o_sts.start_lt   = (r_rd.start_line < r_line);
        o_sts.end_ge     = (r_rd.end_line >= r_line);
        o_sts.end_lt_to  = (r_rd.end_line < r_to);
        o_sts.idx_eq_p   = (r_idx == r_p);
        o_sts.p_eq_count = (r_p == r_count);
        o_sts.full       = (r_count == t_cnt'(MAX_FOLDS));
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    // Result register: load on a finished item, drop when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_op != OUT_NONE) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.out_op)
            OUT_QHIT: begin
                o_contained      <= 1'b1;
                o_head_line      <= r_rd.start_line;
                o_line_after     <= {1'b0, r_rd.end_line} + t_after'(1);
                o_heading_line   <= r_rd.start_line;
                o_refresh_needed <= 1'b0;
                o_table_full     <= 1'b0;
            end
            OUT_QMISS: begin
                o_contained      <= 1'b0;
                o_head_line      <= '0;
                o_line_after     <= {1'b0, r_line};
                o_heading_line   <= r_line;
                o_refresh_needed <= 1'b0;
                o_table_full     <= 1'b0;
            end
            OUT_CREATE: begin
                o_contained      <= 1'b0;
                o_head_line      <= '0;
                o_line_after     <= '0;
                o_heading_line   <= '0;
                o_refresh_needed <= i_cmd.out_refresh;
                o_table_full     <= i_cmd.out_full;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: sv/line_fold_interval_table_core.sv
// Top level of the fold table core: controller plus datapath, with assertions.
// Depends on lfit_pkg, lfit_ctrl, lfit_dpath and the assertion macro header.
//
// Keeps up to MAX_FOLDS line ranges (folds) sorted by start line in a table memory
// with one read and one write port and answers one transaction at a time. A create
// (req_type 0) extends the fold that starts at, or strictly holds, the given start
// line, or inserts a new fold in sorted order; refresh_needed reports a change and
// table_full a dropped insert. A query (req_type 1) reports whether a fold holds the
// line, with its head and the line after it. Every transaction gives exactly one
// result. The table memory is visited one entry per cycle: a query walks a descending
// holder scan; a create walks an ascending head scan, then, unless a head matches, a
// descending holder scan and, for an insert, a shift of the entries above the insert
// point. A finished result waits while the output register is stalled. The input
// stalls from acceptance until the result is loaded into the output register; a
// waiting result does not block the next transaction from being accepted. The table
// needs no clearing pass after reset: only entries below the fold count are ever used.
module line_fold_interval_table_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_req_type,
    input  lfit_pkg::t_line  i_line,
    input  lfit_pkg::t_line  i_end_line,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_contained,
    output lfit_pkg::t_line  o_head_line,
    output lfit_pkg::t_after o_line_after,
    output lfit_pkg::t_line  o_heading_line,
    output logic             o_refresh_needed,
    output logic             o_table_full
);
    import lfit_pkg::*;

    `include "line_fold_interval_table_core_macros.svh"

    // Command and status between the sequencer and the datapath
    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer: hold the input stalled while a transaction is at work
    lfit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // Datapath: fold memory, scan index, compares and the result register
    lfit_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_req_type       (i_req_type),
        .i_line           (i_line),
        .i_end_line       (i_end_line),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_contained      (o_contained),
        .o_head_line      (o_head_line),
        .o_line_after     (o_line_after),
        .o_heading_line   (o_heading_line),
        .o_refresh_needed (o_refresh_needed),
        .o_table_full     (o_table_full)
    );

    // An accepted transaction keeps the input stalled in the next cycle.
    `LFIT_ASSERT_NEXT(a_stall_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // Only one table write per cycle: extend, shift and insert never overlap.
    `LFIT_ASSERT(a_one_write, i_clk, i_rst_n, $onehot0({w_cmd.wr_end, w_cmd.wr_shift, w_cmd.wr_insert}))
    // A dropped insert reports nothing else.
    `LFIT_ASSERT(a_full_alone, i_clk, i_rst_n, !(o_out_valid && o_table_full) || (!o_refresh_needed && !o_contained))
    // A query hit never carries create flags and always has a nonzero line after.
    `LFIT_ASSERT(a_hit_clean, i_clk, i_rst_n, !(o_out_valid && o_contained) || (!o_refresh_needed && !o_table_full && (o_line_after != 0)))

endmodule

// File: verif/line_fold_interval_table_core_test.sv
// Self-checking testbench for line_fold_interval_table_core: directed table, then random.
// Depends on lfit_pkg and the core; the fold table predictor and all stimulus live here.
`timescale 1ns / 100ps

module line_fold_interval_table_core_test;
    import lfit_pkg::*;

    // Request kinds carried on i_req_type
    localparam logic REQ_CREATE = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam int WAIT_MAX       = 19;
    localparam int RANDOM_ITEMS   = 1875;
    localparam int MISMATCH_SHOWN = 10;
    // Wait after the last result, sized to cover the longest create with margin
    localparam int DRAIN_CYCLES   = 3 * MAX_FOLDS + 8;
    // Cycles in which no transaction moves on either side before the run is declared hung
    localparam int IDLE_LIMIT     = 2000;

    // One result transaction, in port order
    typedef struct packed {
        logic   contained;
        t_line  head_line;
        t_after line_after;
        t_line  heading_line;
        logic   refresh_needed;
        logic   table_full;
    } t_fold_result;

    // One row of the directed table; typed rows carry their own expected result
    typedef struct packed {
        logic         req;
        t_line        ln;
        t_line        end_ln;
        logic         typed;
        t_fold_result res;
    } t_stim_row;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_in_valid = 1'b0;
    logic   o_in_stall;
    logic   i_req_type = REQ_CREATE;
    t_line  i_line = '0;
    t_line  i_end_line = '0;
    logic   o_out_valid;
    logic   i_out_stall = 1'b0;
    logic   o_contained;
    t_line  o_head_line;
    t_after o_line_after;
    t_line  o_heading_line;
    logic   o_refresh_needed;
    logic   o_table_full;

    // Predictor copy of the fold table
    t_line  model_start [MAX_FOLDS];
    t_line  model_end   [MAX_FOLDS];
    int     model_count = 0;

    t_fold_result fold_results_due [$];
    int           failures = 0;
    int           idle_cycles = 0;
    int           out_hold = 0;
    bit           quiet = 1'b0;
    t_fold_result due_res;
    t_fold_result seen_res;

    int    n;
    int    pick;
    int    k;
    logic  req;
    t_line ln;
    t_line end_ln;
    t_line base_s;
    t_line base_e;

    // Directed rows: empty table, line extremes, end+1 carry into bit 20, no-larger extend,
    // line 0, extend from inside, nested insert, end below start, fill to full, dropped
    // insert, extend on a full table.
    t_stim_row directed_rows [0:24] = '{
        '{REQ_QUERY,  20'h00000, 20'h00000, 1'b1, '{1'b0, 20'h0, 21'h0, 20'h0, 1'b0, 1'b0}},
        '{REQ_QUERY,  20'hFFFFF, 20'h00000, 1'b1,
          '{1'b0, 20'h0, 21'h0FFFFF, 20'hFFFFF, 1'b0, 1'b0}},
        '{REQ_CREATE, 20'hFFFFE, 20'hFFFFF, 1'b1, '{1'b0, 20'h0, 21'h0, 20'h0, 1'b1, 1'b0}},
        '{REQ_QUERY,  20'hFFFFF, 20'h00000, 1'b1,
          '{1'b1, 20'hFFFFE, 21'h100000, 20'hFFFFE, 1'b0, 1'b0}},
        '{REQ_CREATE, 20'hFFFFE, 20'h00010, 1'b1, '{1'b0, 20'h0, 21'h0, 20'h0, 1'b0, 1'b0}},
        '{REQ_CREATE, 20'h00000, 20'h00000, 1'b1, '{1'b0, 20'h0, 21'h0, 20'h0, 1'b1, 1'b0}},
        '{REQ_CREATE, 20'd100,   20'd200,   1'b0, '0},
        '{REQ_CREATE, 20'd150,   20'd400,   1'b0, '0},
        '{REQ_CREATE, 20'd50,    20'd300,   1'b0, '0},
        '{REQ_QUERY,  20'd250,   20'hABCDE, 1'b0, '0},
        '{REQ_CREATE, 20'd1000,  20'd900,   1'b0, '0},
        '{REQ_CREATE, 20'h10000, 20'h10100, 1'b0, '0},
        '{REQ_CREATE, 20'h80000, 20'h80100, 1'b0, '0},
        '{REQ_CREATE, 20'h00400, 20'h00500, 1'b0, '0},
        '{REQ_CREATE, 20'h40000, 20'h40100, 1'b0, '0},
        '{REQ_CREATE, 20'h00800, 20'h00900, 1'b0, '0},
        '{REQ_CREATE, 20'hC0000, 20'hC0100, 1'b0, '0},
        '{REQ_CREATE, 20'h01000, 20'h01100, 1'b0, '0},
        '{REQ_CREATE, 20'h20000, 20'h20100, 1'b0, '0},
        '{REQ_CREATE, 20'h00200, 20'h00210, 1'b0, '0},
        '{REQ_CREATE, 20'h7FFFF, 20'h7FFFF, 1'b0, '0},
        '{REQ_CREATE, 20'h08000, 20'h08100, 1'b0, '0},
        '{REQ_CREATE, 20'hFFFFD, 20'h00000, 1'b1, '{1'b0, 20'h0, 21'h0, 20'h0, 1'b0, 1'b1}},
        '{REQ_CREATE, 20'h10000, 20'h1FFFF, 1'b1, '{1'b0, 20'h0, 21'h0, 20'h0, 1'b1, 1'b0}},
        '{REQ_QUERY,  20'h18000, 20'h00000, 1'b0, '0}
    };

    line_fold_interval_table_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_line           (i_line),
        .i_end_line       (i_end_line),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_contained      (o_contained),
        .o_head_line      (o_head_line),
        .o_line_after     (o_line_after),
        .o_heading_line   (o_heading_line),
        .o_refresh_needed (o_refresh_needed),
        .o_table_full     (o_table_full)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Cycles to wait before the next transaction on either side; zero inside quiet stretches
    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, WAIT_MAX);
    endfunction

    // Scan from the highest start downward; stop at the first fold ending below ln.
    // The first fold met that starts below ln holds it.
    function automatic int holding_fold(t_line ln_q);
        int i;
        i = model_count - 1;
        while (i >= 0 && model_end[i] >= ln_q) begin
            if (model_start[i] < ln_q)
                return i;
            i--;
        end
        return -1;
    endfunction

    // Compute the result of one transaction and advance the predictor's table
    function automatic t_fold_result predict_fold_result(logic req_q, t_line ln_q, t_line to_q);
        t_fold_result r;
        int           h;
        int           p;
        int           i;
        r = '0;
        if (req_q == REQ_QUERY) begin
            h = holding_fold(ln_q);
            if (h >= 0) begin
                r.contained    = 1'b1;
                r.head_line    = model_start[h];
                r.line_after   = t_after'(model_end[h]) + 1'b1;
                r.heading_line = model_start[h];
            end else begin
                r.line_after   = t_after'(ln_q);
                r.heading_line = ln_q;
            end
            return r;
        end
        // Create: a fold head wins over a holder
        h = -1;
        for (i = 0; i < model_count; i++)
            if (h < 0 && model_start[i] == ln_q)
                h = i;
        if (h < 0)
            h = holding_fold(ln_q);
        if (h >= 0) begin
            // Raise the end only when the new end is larger
            if (model_end[h] < to_q) begin
                model_end[h]     = to_q;
                r.refresh_needed = 1'b1;
            end
        end else if (model_count >= MAX_FOLDS) begin
            r.table_full = 1'b1;
        end else begin
            // Insert in sorted order, shifting the entries above up by one
            p = 0;
            while (p < model_count && model_start[p] < ln_q)
                p++;
            for (i = model_count; i > p; i--) begin
                model_start[i] = model_start[i-1];
                model_end[i]   = model_end[i-1];
            end
            model_start[p]   = ln_q;
            model_end[p]     = to_q;
            model_count++;
            r.refresh_needed = 1'b1;
        end
        return r;
    endfunction

    // Present one request transaction, hold it until accepted, then queue its expected result.
    // A zero gap keeps valid high straight into the next transaction.
    task automatic send_request(input logic req_q, input t_line ln_q, input t_line to_q,
                                input logic typed, input t_fold_result typed_res);
        int           gap;
        t_fold_result r;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req_q;
        i_line     <= ln_q;
        i_end_line <= to_q;
        do @(posedge i_clk); while (o_in_stall);
        r = predict_fold_result(req_q, ln_q, to_q);
        fold_results_due.push_back(typed ? typed_res : r);
    endtask

    // Drop valid and hold the sender off until every outstanding result has been taken
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        while (fold_results_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Result side: check each accepted result against the oldest expectation, then
    // draw how long to stall before taking the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_hold = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                seen_res = {o_contained, o_head_line, o_line_after, o_heading_line,
                            o_refresh_needed, o_table_full};
                if (fold_results_due.size() == 0) begin
                    failures++;
                    if (failures <= MISMATCH_SHOWN)
                        $display({"unexpected result: contained %0d head %h after %h",
                                  " heading %h refresh %0d full %0d"},
                                 seen_res.contained, seen_res.head_line, seen_res.line_after,
                                 seen_res.heading_line, seen_res.refresh_needed,
                                 seen_res.table_full);
                end else begin
                    due_res = fold_results_due.pop_front();
                    if (seen_res !== due_res) begin
                        failures++;
                        if (failures <= MISMATCH_SHOWN) begin
                            $display({"mismatch: expected contained %0d head %h after %h",
                                      " heading %h refresh %0d full %0d"},
                                     due_res.contained, due_res.head_line, due_res.line_after,
                                     due_res.heading_line, due_res.refresh_needed,
                                     due_res.table_full);
                            $display({"          actual   contained %0d head %h after %h",
                                      " heading %h refresh %0d full %0d"},
                                     seen_res.contained, seen_res.head_line,
                                     seen_res.line_after, seen_res.heading_line,
                                     seen_res.refresh_needed, seen_res.table_full);
                        end
                    end
                end
                out_hold = draw_wait();
            end
            if (out_hold > 0) begin
                i_out_stall <= 1'b1;
                out_hold--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either side for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    initial begin
        // Hold reset asserted at the start, then release it
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (n = 0; n < $size(directed_rows); n++)
            send_request(directed_rows[n].req, directed_rows[n].ln, directed_rows[n].end_ln,
                         directed_rows[n].typed, directed_rows[n].res);

        // Random part. The table is full by now, so aim mostly at existing folds:
        // queries around heads and ends, extends at heads and from inside, plus noise.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= 500 && n < 700) || (n >= 1300 && n < 1400);
            if (n % 450 == 449)
                hold_until_drained();
            pick   = $urandom_range(0, 99);
            k      = $urandom_range(0, model_count - 1);
            base_s = model_start[k];
            base_e = model_end[k];
            end_ln = t_line'($urandom);
            if (pick < 45) begin
                req = REQ_QUERY;
                case ($urandom_range(0, 7))
                    0:       ln = base_s - 1'b1;
                    1:       ln = base_s;
                    2:       ln = base_s + 1'b1;
                    3:       ln = base_e;
                    4:       ln = base_e + 1'b1;
                    5:       ln = base_s + t_line'($urandom_range(0, 255));
                    default: ln = t_line'($urandom);
                endcase
            end else if (pick < 80) begin
                // Extend at a head: larger, equal, smaller, or anything
                req = REQ_CREATE;
                ln  = base_s;
                case ($urandom_range(0, 7))
                    0, 1, 2: end_ln = base_e + t_line'($urandom_range(1, 255));
                    3:       end_ln = base_e;
                    4, 5, 6: end_ln = base_e - t_line'($urandom_range(0, 255));
                    default: end_ln = t_line'($urandom);
                endcase
            end else if (pick < 90) begin
                // Create starting inside a fold
                req    = REQ_CREATE;
                ln     = base_s + t_line'($urandom_range(1, 256));
                end_ln = base_e + t_line'($urandom_range(0, 4095)) - t_line'(2048);
            end else begin
                req = logic'($urandom_range(0, 1));
                ln  = t_line'($urandom);
            end
            send_request(req, ln, end_ln, 1'b0, '0);
        end

        // Drain, then give the block time to show any stray result
        i_in_valid <= 1'b0;
        while (fold_results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (failures == 0 && fold_results_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
